### rtl/core/seven_segment_display_commander_macros.svh
// ----------------------------------------------------------------------------
// Seven-segment display commander assertion macros
// Shorthand for clocked implications checked against clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DISPLAY_COMMANDER_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_COMMANDER_MACROS_SVH

// same-cycle implication
`define SSDC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ssdc_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment display commander package
// Driver register map, segment codes, command job type and letter tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdc_pkg;

    localparam int MAX_DIGITS = 8;

    // driver register addresses
    localparam logic [3:0] REG_DIGIT0 = 4'h1;
    localparam logic [3:0] REG_DECODE = 4'h9;
    localparam logic [3:0] REG_INTENS = 4'hA;
    localparam logic [3:0] REG_SCAN   = 4'hB;
    localparam logic [3:0] REG_SHUT   = 4'hC;
    localparam logic [3:0] REG_TEST   = 4'hF;

    localparam logic [7:0] CODE_DASH  = 8'h0A;
    localparam logic [7:0] CODE_BLANK = 8'h0F;
    localparam logic [7:0] POINT_BIT  = 8'h80;
    localparam logic [7:0] DECODE_ALL = 8'hFF;
    localparam logic [7:0] DECODE_OFF = 8'h00;
    localparam logic [7:0] INTENS_MAX = 8'h0F;
    localparam logic [7:0] INTENS_DEF = 8'h07;

    localparam logic [7:0] SG_A = 8'h40;
    localparam logic [7:0] SG_B = 8'h20;
    localparam logic [7:0] SG_C = 8'h10;
    localparam logic [7:0] SG_D = 8'h08;
    localparam logic [7:0] SG_E = 8'h04;
    localparam logic [7:0] SG_F = 8'h02;
    localparam logic [7:0] SG_G = 8'h01;

    // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_NUMBER = 3'd1,
        OP_DIGIT  = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_DASH   = 3'd4,
        OP_STATE  = 3'd5,
        OP_BRIGHT = 3'd6,
        OP_ENABLE = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        K_INIT,
        K_NUMBER,
        K_DIGIT,
        K_CLEAR,
        K_DASH,
        K_STATE,
        K_WORD
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        neg;
        logic [30:0] mag;
        logic [3:0]  addr;
        logic [7:0]  data;
        logic [7:0]  data2;
        logic [3:0]  count;
    } job_t;

    function automatic logic [7:0] left_pattern(input logic [7:0] c);
        logic [7:0] p;
        unique case (c) inside
            8'h48, 8'h68: p = SG_B | SG_C | SG_E | SG_F | SG_G;
            8'h49, 8'h69: p = SG_E | SG_F;
            8'h41, 8'h61: p = SG_A | SG_B | SG_C | SG_E | SG_F | SG_G;
            8'h46, 8'h66: p = SG_A | SG_E | SG_F | SG_G;
            8'h44, 8'h64: p = SG_B | SG_C | SG_D | SG_E | SG_G;
            8'h53, 8'h73: p = SG_A | SG_C | SG_D | SG_F | SG_G;
            8'h20:        p = 8'h00;
            default:      p = SG_G;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] right_pattern(input logic [7:0] c);
        logic [7:0] p;
        unique case (c) inside
            8'h4F, 8'h6F: p = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
            8'h44, 8'h64: p = SG_B | SG_C | SG_D | SG_E | SG_G;
            8'h54, 8'h74: p = SG_D | SG_E | SG_F | SG_G;
            8'h53, 8'h73: p = SG_A | SG_C | SG_D | SG_F | SG_G;
            8'h41, 8'h61: p = SG_A | SG_B | SG_C | SG_E | SG_F | SG_G;
            8'h46, 8'h66: p = SG_A | SG_E | SG_F | SG_G;
            8'h20:        p = 8'h00;
            default:      p = SG_G;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/core/seven_segment_display_commander.sv
// ----------------------------------------------------------------------------
// Seven-segment display commander
// Expands display commands into register words for an 8-digit segment driver.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   cmd_valid / cmd_ready     operation .. enable_on
//  word      word_valid / word_ready   reg_address, reg_data, last_word
//  config    cfg_write_en              cfg_write_data (digit count)
//
// A command is taken while the two-entry job queue has room.
// The sequencer loads a job while idle, then writes one word per cycle into
// the output register while that register is free or word_ready is high.
// Reset clears the queue, sets digit count to 1 and BCD decode on.
// word_ready low holds the output register and the sequencer; the queue
// keeps taking commands until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_display_commander
    import ssdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [3:0]         cfg_write_data,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire logic [2:0]         operation,
    input  wire logic signed [31:0] number,
    input  wire logic [2:0]         digit_index,
    input  wire logic [7:0]         digit_code,
    input  wire logic               point_on,
    input  wire logic [7:0]         left_char,
    input  wire logic [7:0]         right_char,
    input  wire logic [7:0]         brightness,
    input  wire logic               enable_on,
    output logic                    word_valid,
    input  wire logic               word_ready,
    output logic [3:0]              reg_address,
    output logic [7:0]              reg_data,
    output logic                    last_word
);

    logic q_push;
    logic q_push_ready;
    job_t q_push_job;
    logic q_pop;
    logic q_pop_valid;
    job_t q_pop_job;

    ssdc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .operation      (operation),
        .number         (number),
        .digit_index    (digit_index),
        .digit_code     (digit_code),
        .point_on       (point_on),
        .left_char      (left_char),
        .right_char     (right_char),
        .brightness     (brightness),
        .enable_on      (enable_on),
        .q_ready        (q_push_ready),
        .push           (q_push),
        .push_job       (q_push_job)
    );

    ssdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_pop_valid),
        .pop_job    (q_pop_job)
    );

    ssdc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_pop_valid),
        .q_job       (q_pop_job),
        .pop         (q_pop),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .reg_address (reg_address),
        .reg_data    (reg_data),
        .last_word   (last_word)
    );

endmodule

`default_nettype wire

### rtl/core/ssdc_front.sv
// ----------------------------------------------------------------------------
// Seven-segment display commander front end
// Holds the digit count, accepts commands and turns each into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdc_front
    import ssdc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [3:0]        cfg_write_data,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire logic [2:0]        operation,
    input  wire logic signed [31:0] number,
    input  wire logic [2:0]        digit_index,
    input  wire logic [7:0]        digit_code,
    input  wire logic              point_on,
    input  wire logic [7:0]        left_char,
    input  wire logic [7:0]        right_char,
    input  wire logic [7:0]        brightness,
    input  wire logic              enable_on,
    input  wire logic              q_ready,
    output logic                   push,
    output job_t                   push_job
);

    logic [3:0]  digit_count_reg;
    logic [3:0]  digit_count_next;
    logic [31:0] neg_val;
    logic        drop;

    always_comb
    begin
        digit_count_next = cfg_write_data;
        if (cfg_write_data == 4'd0)
        begin
            digit_count_next = 4'd1;
        end
        else if (cfg_write_data > 4'(MAX_DIGITS))
        begin
            digit_count_next = 4'(MAX_DIGITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= 4'd1;
        end
        else if (cfg_write_en)
        begin
            digit_count_reg <= digit_count_next;
        end
    end

    assign neg_val = 32'd0 - $unsigned(number);

    always_comb
    begin
        drop             = 1'b0;
        push_job.kind    = K_WORD;
        push_job.neg     = 1'b0;
        push_job.mag     = '0;
        push_job.addr    = '0;
        push_job.data    = '0;
        push_job.data2   = '0;
        push_job.count   = 4'd1;
        unique case (op_t'(operation))
            OP_INIT:
            begin
                push_job.kind  = K_INIT;
                push_job.data  = {4'd0, digit_count_reg - 4'd1};
                push_job.count = 4'(MAX_DIGITS);
            end
            OP_NUMBER:
            begin
                push_job.kind  = K_NUMBER;
                push_job.neg   = number[31];
                push_job.count = digit_count_reg;
                if (!number[31])
                begin
                    push_job.mag = number[30:0];
                end
                else if (neg_val[31])
                begin
                    push_job.mag = 31'h7FFFFFFF;
                end
                else
                begin
                    push_job.mag = neg_val[30:0];
                end
            end
            OP_DIGIT:
            begin
                drop          = ({1'b0, digit_index} >= digit_count_reg);
                push_job.kind = K_DIGIT;
                push_job.addr = {1'b0, digit_index} + REG_DIGIT0;
                push_job.data = (point_on ? POINT_BIT : 8'h00) | {4'd0, digit_code[3:0]};
            end
            OP_CLEAR:
            begin
                push_job.kind  = K_CLEAR;
                push_job.count = 4'(MAX_DIGITS);
            end
            OP_DASH:
            begin
                push_job.kind  = K_DASH;
                push_job.count = digit_count_reg;
            end
            OP_STATE:
            begin
                drop           = (digit_count_reg < 4'd2);
                push_job.kind  = K_STATE;
                push_job.data  = left_pattern(left_char);
                push_job.data2 = right_pattern(right_char);
                push_job.count = digit_count_reg;
            end
            OP_BRIGHT:
            begin
                push_job.addr = REG_INTENS;
                push_job.data = (brightness > INTENS_MAX) ? INTENS_MAX : brightness;
            end
            OP_ENABLE:
            begin
                push_job.addr = REG_SHUT;
                push_job.data = {7'd0, enable_on};
            end
            default:
            begin
                drop = 1'b1;
            end
        endcase
    end

    // commands that produce no word are taken and dropped here
    assign cmd_ready = q_ready;
    assign push      = cmd_valid && q_ready && !drop;

endmodule

`default_nettype wire

### rtl/core/ssdc_queue.sv
// ----------------------------------------------------------------------------
// Seven-segment display commander job queue
// Two-entry queue between the front end and the word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdc_queue
    import ssdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output job_t      pop_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/ssdc_back.sv
// ----------------------------------------------------------------------------
// Seven-segment display commander word sequencer
// Expands each job into driver words, one per cycle when not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdc_back
    import ssdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire job_t q_job,
    output logic      pop,
    output logic      word_valid,
    input  wire logic word_ready,
    output logic [3:0] reg_address,
    output logic [7:0] reg_data,
    output logic      last_word
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PRO  = 4'b0010,
        ST_DEC  = 4'b0100,
        ST_BODY = 4'b1000
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    job_t        job_reg, job_next;
    logic        decode_active_reg, decode_active_next;
    logic        out_valid_reg;
    logic [3:0]  out_addr_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;

    logic        adv;
    logic        emit;
    logic [3:0]  w_addr;
    logic [7:0]  w_data;
    logic        w_last;
    logic [3:0]  pos_addr;

    // divide by ten through the reciprocal, one digit per word
    logic [62:0] prod;
    logic [27:0] quot;
    logic [3:0]  quot_x10;
    logic [3:0]  rem;

    assign prod     = {32'd0, job_reg.mag} * {31'd0, RECIP_TEN};
    assign quot     = prod[62:35];
    assign quot_x10 = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign rem      = job_reg.mag[3:0] - quot_x10;

    assign adv      = !out_valid_reg || word_ready;
    assign emit     = (state_reg != ST_IDLE) && adv;
    assign pos_addr = {1'b0, step_reg} + REG_DIGIT0;

    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        job_next           = job_reg;
        decode_active_next = decode_active_reg;
        pop                = 1'b0;
        w_addr             = '0;
        w_data             = '0;
        w_last             = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    job_next  = q_job;
                    step_next = 3'd0;
                    case (q_job.kind)
                        K_INIT:  state_next = ST_PRO;
                        K_WORD:  state_next = ST_BODY;
                        K_STATE: state_next = decode_active_reg ? ST_DEC : ST_BODY;
                        default: state_next = decode_active_reg ? ST_BODY : ST_DEC;
                    endcase
                end
            end
            ST_PRO:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        w_addr = REG_SHUT;
                        w_data = 8'h01;
                    end
                    3'd1:
                    begin
                        w_addr = REG_TEST;
                        w_data = 8'h00;
                    end
                    3'd2:
                    begin
                        w_addr = REG_SCAN;
                        w_data = job_reg.data;
                    end
                    3'd3:
                    begin
                        w_addr = REG_DECODE;
                        w_data = DECODE_ALL;
                    end
                    default:
                    begin
                        w_addr = REG_INTENS;
                        w_data = INTENS_DEF;
                    end
                endcase
                if (emit)
                begin
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd3)
                    begin
                        decode_active_next = 1'b1;
                    end
                    if (step_reg == 3'd4)
                    begin
                        state_next = ST_BODY;
                        step_next  = 3'd0;
                    end
                end
            end
            ST_DEC:
            begin
                w_addr = REG_DECODE;
                w_data = (job_reg.kind == K_STATE) ? DECODE_OFF : DECODE_ALL;
                if (emit)
                begin
                    decode_active_next = (job_reg.kind != K_STATE);
                    state_next         = ST_BODY;
                end
            end
            ST_BODY:
            begin
                w_last = ({1'b0, step_reg} == job_reg.count - 4'd1);
                w_addr = pos_addr;
                case (job_reg.kind)
                    K_INIT, K_CLEAR:
                    begin
                        w_data = CODE_BLANK;
                    end
                    K_DASH:
                    begin
                        w_data = CODE_DASH;
                    end
                    K_NUMBER:
                    begin
                        if (step_reg == 3'd0 || job_reg.mag != 31'd0)
                        begin
                            w_data = {4'd0, rem};
                            if (emit)
                            begin
                                job_next.mag = {3'd0, quot};
                            end
                        end
                        else if (job_reg.neg)
                        begin
                            w_data = CODE_DASH;
                            if (emit)
                            begin
                                job_next.neg = 1'b0;
                            end
                        end
                        else
                        begin
                            w_data = CODE_BLANK;
                        end
                    end
                    K_STATE:
                    begin
                        // left letter sits on the second digit, right on the first
                        if (step_reg == 3'd0)
                        begin
                            w_addr = REG_DIGIT0 + 4'd1;
                            w_data = job_reg.data;
                        end
                        else if (step_reg == 3'd1)
                        begin
                            w_addr = REG_DIGIT0;
                            w_data = job_reg.data2;
                        end
                        else
                        begin
                            w_data = 8'h00;
                        end
                    end
                    default:
                    begin
                        w_addr = job_reg.addr;
                        w_data = job_reg.data;
                    end
                endcase
                if (emit)
                begin
                    step_next = step_reg + 3'd1;
                    if (w_last)
                    begin
                        state_next = ST_IDLE;
                        step_next  = 3'd0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            step_reg          <= 3'd0;
            decode_active_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            step_reg          <= step_next;
            decode_active_reg <= decode_active_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (word_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit)
        begin
            out_addr_reg <= w_addr;
            out_data_reg <= w_data;
            out_last_reg <= w_last;
        end
    end

    assign word_valid  = out_valid_reg;
    assign reg_address = out_addr_reg;
    assign reg_data    = out_data_reg;
    assign last_word   = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/ssdc_checker.sv
// ----------------------------------------------------------------------------
// Seven-segment display commander port checker
// Watches the word channel for handshake and register-map consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_display_commander_macros.svh"

module ssdc_checker
    import ssdc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       word_valid,
    input  wire logic       word_ready,
    input  wire logic [3:0] reg_address,
    input  wire logic [7:0] reg_data,
    input  wire logic       last_word
);

    `SSDC_ASSERT_NEXT(a_word_hold, word_valid && !word_ready, word_valid && $stable(reg_address) && $stable(reg_data) && $stable(last_word), "word changed while stalled")

    `SSDC_ASSERT_IMPLIES(a_addr_map, word_valid, reg_address != 4'h0 && reg_address != 4'hD && reg_address != 4'hE, "word to unused driver register")

    `SSDC_ASSERT_IMPLIES(a_decode_data, word_valid && reg_address == REG_DECODE, (reg_data == DECODE_ALL || reg_data == DECODE_OFF) && !last_word, "bad decode word")

    `SSDC_ASSERT_IMPLIES(a_intens_range, word_valid && reg_address == REG_INTENS, reg_data <= INTENS_MAX, "intensity above limit")

endmodule

bind seven_segment_display_commander ssdc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .reg_address (reg_address),
    .reg_data    (reg_data),
    .last_word   (last_word)
);

`default_nettype wire

### dv/tb_seven_segment_display_commander.sv
// ----------------------------------------------------------------------------
// Seven-segment display commander testbench
// Sends display commands through a stimulus table and then random traffic.
// Every register word is checked against an in-bench expansion of each
// command or a word given in the table. Both handshakes stall at random
// except in a final steady phase, and digit count is changed between phases.
// ----------------------------------------------------------------------------
module tb_seven_segment_display_commander
    import ssdc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED    = 27;
    localparam int N_RANDOM      = 140;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] number;
        logic [2:0]         digit_index;
        logic [7:0]         digit_code;
        logic               point_on;
        logic [7:0]         left_char;
        logic [7:0]         right_char;
        logic [7:0]         brightness;
        logic               enable_on;
    } command_t;

    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] data;
        logic       last;
    } reg_word_t;

    // one table row: either a digit-count write or a command; typed rows carry
    // their expected word (or none) instead of using the expansion
    typedef struct packed {
        logic       cfg_row;
        logic [3:0] cfg_value;
        command_t   cmd;
        logic       typed;
        logic       has_word;
        logic [3:0] exp_addr;
        logic [7:0] exp_data;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [3:0]         cfg_write_data;
    logic               cmd_valid;
    logic               cmd_ready;
    logic [2:0]         operation;
    logic signed [31:0] number;
    logic [2:0]         digit_index;
    logic [7:0]         digit_code;
    logic               point_on;
    logic [7:0]         left_char;
    logic [7:0]         right_char;
    logic [7:0]         brightness;
    logic               enable_on;
    logic               word_valid;
    logic               word_ready;
    logic [3:0]         reg_address;
    logic [7:0]         reg_data;
    logic               last_word;

    seven_segment_display_commander i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .operation      (operation),
        .number         (number),
        .digit_index    (digit_index),
        .digit_code     (digit_code),
        .point_on       (point_on),
        .left_char      (left_char),
        .right_char     (right_char),
        .brightness     (brightness),
        .enable_on      (enable_on),
        .word_valid     (word_valid),
        .word_ready     (word_ready),
        .reg_address    (reg_address),
        .reg_data       (reg_data),
        .last_word      (last_word)
    );

    // display state as the block should hold it
    int unsigned digit_count_model = 1;
    bit          decode_on = 1'b1;

    reg_word_t   predicted[$];
    reg_word_t   expected_words[$];
    plan_row_t   cmd_fifo[$];
    plan_row_t   cmd_on_bus;
    reg_word_t   popped_word;
    int          in_flight;
    int          errors;
    int          send_gap;
    int          recv_gap;
    int          cycles;
    bit          steady_flow;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void add_word(input logic [3:0] addr, input logic [7:0] data);
        predicted.push_back({addr, data, 1'b0});
    endfunction

    function automatic void require_decode(input bit on);
        if (on != decode_on)
        begin
            decode_on = on;
            add_word(REG_DECODE, on ? 8'hFF : 8'h00);
        end
    endfunction

    function automatic void blank_digits();
        require_decode(1'b1);
        for (int i = 0; i < MAX_DIGITS; i++)
            add_word(4'(REG_DIGIT0 + i), CODE_BLANK);
    endfunction

    function automatic logic [7:0] letter_segments(input logic [7:0] c, input bit left_side);
        case (c)
            "A", "a": return SG_A | SG_B | SG_C | SG_E | SG_F | SG_G;
            "F", "f": return SG_A | SG_E | SG_F | SG_G;
            "D", "d": return SG_B | SG_C | SG_D | SG_E | SG_G;
            "S", "s": return SG_A | SG_C | SG_D | SG_F | SG_G;
            " ":      return 8'h00;
            "H", "h": return left_side ? (SG_B | SG_C | SG_E | SG_F | SG_G) : SG_G;
            "I", "i": return left_side ? (SG_E | SG_F) : SG_G;
            "O", "o": return left_side ? SG_G : (SG_A | SG_B | SG_C | SG_D | SG_E | SG_F);
            "T", "t": return left_side ? SG_G : (SG_D | SG_E | SG_F | SG_G);
            default:  return SG_G;
        endcase
    endfunction

    // expand one accepted command into the words it should produce
    function automatic void expand_command(input command_t c);
        logic [31:0] mag;
        bit          neg;
        predicted.delete();
        case (c.operation)
            OP_INIT:
            begin
                add_word(REG_SHUT, 8'h01);
                add_word(REG_TEST, 8'h00);
                add_word(REG_SCAN, 8'(digit_count_model - 1));
                add_word(REG_DECODE, DECODE_ALL);
                decode_on = 1'b1;
                add_word(REG_INTENS, INTENS_DEF);
                blank_digits();
            end
            OP_NUMBER:
            begin
                neg = c.number[31];
                mag = neg ? -c.number : c.number;
                if (mag > 32'h7FFF_FFFF)
                    mag = 32'h7FFF_FFFF;
                require_decode(1'b1);
                for (int i = 0; i < digit_count_model; i++)
                begin
                    if (i == 0 || mag > 0)
                    begin
                        add_word(4'(REG_DIGIT0 + i), 8'(mag % 10));
                        mag = mag / 10;
                    end
                    else if (neg)
                    begin
                        add_word(4'(REG_DIGIT0 + i), CODE_DASH);
                        neg = 1'b0;
                    end
                    else
                        add_word(4'(REG_DIGIT0 + i), CODE_BLANK);
                end
            end
            OP_DIGIT:
            begin
                if (c.digit_index < digit_count_model)
                begin
                    require_decode(1'b1);
                    add_word(4'(REG_DIGIT0 + c.digit_index),
                             {c.point_on, 3'b000, c.digit_code[3:0]});
                end
            end
            OP_CLEAR:
                blank_digits();
            OP_DASH:
            begin
                require_decode(1'b1);
                for (int i = 0; i < digit_count_model; i++)
                    add_word(4'(REG_DIGIT0 + i), CODE_DASH);
            end
            OP_STATE:
            begin
                if (digit_count_model >= 2)
                begin
                    require_decode(1'b0);
                    add_word(4'(REG_DIGIT0 + 1), letter_segments(c.left_char, 1'b1));
                    add_word(REG_DIGIT0, letter_segments(c.right_char, 1'b0));
                    for (int i = 2; i < digit_count_model; i++)
                        add_word(4'(REG_DIGIT0 + i), 8'h00);
                end
            end
            OP_BRIGHT:
                add_word(REG_INTENS, (c.brightness > 15) ? INTENS_MAX : c.brightness);
            default:
                add_word(REG_SHUT, {7'b0, c.enable_on});
        endcase
        if (predicted.size() > 0)
            predicted[predicted.size() - 1].last = 1'b1;
    endfunction

    // command side: take a command from the fifo, hold it until accepted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid   <= 1'b0;
            operation   <= '0;
            number      <= '0;
            digit_index <= '0;
            digit_code  <= '0;
            point_on    <= 1'b0;
            left_char   <= '0;
            right_char  <= '0;
            brightness  <= '0;
            enable_on   <= 1'b0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                expand_command(cmd_on_bus.cmd);
                if (cmd_on_bus.typed)
                begin
                    predicted.delete();
                    if (cmd_on_bus.has_word)
                        predicted.push_back({cmd_on_bus.exp_addr, cmd_on_bus.exp_data, 1'b1});
                end
                foreach (predicted[k])
                    expected_words.push_back(predicted[k]);
                in_flight--;
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_fifo.size() == 0)
                    cmd_valid <= 1'b0;
                else if (!steady_flow && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 6);
                    cmd_valid <= 1'b0;
                end
                else
                begin
                    cmd_on_bus = cmd_fifo.pop_front();
                    operation   <= cmd_on_bus.cmd.operation;
                    number      <= cmd_on_bus.cmd.number;
                    digit_index <= cmd_on_bus.cmd.digit_index;
                    digit_code  <= cmd_on_bus.cmd.digit_code;
                    point_on    <= cmd_on_bus.cmd.point_on;
                    left_char   <= cmd_on_bus.cmd.left_char;
                    right_char  <= cmd_on_bus.cmd.right_char;
                    brightness  <= cmd_on_bus.cmd.brightness;
                    enable_on   <= cmd_on_bus.cmd.enable_on;
                    cmd_valid   <= 1'b1;
                end
            end
        end
    end

    // word side: stall in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            word_ready <= 1'b0;
        end
        else
        begin
            if (recv_gap > 0)
            begin
                recv_gap--;
                word_ready <= 1'b0;
            end
            else if (!steady_flow && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 6);
                word_ready <= 1'b0;
            end
            else
                word_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && word_valid && word_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word addr=%h data=%h last=%b",
                         $time, reg_address, reg_data, last_word);
                errors++;
            end
            else
            begin
                popped_word = expected_words.pop_front();
                if (reg_address !== popped_word.addr)
                begin
                    $display("%0t: reg_address expected %h, got %h",
                             $time, popped_word.addr, reg_address);
                    errors++;
                end
                if (reg_data !== popped_word.data)
                begin
                    $display("%0t: reg_data expected %h, got %h",
                             $time, popped_word.data, reg_data);
                    errors++;
                end
                if (last_word !== popped_word.last)
                begin
                    $display("%0t: last_word expected %b, got %b",
                             $time, popped_word.last, last_word);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // wait for every word, then let commands that make no word leave the queue
    task automatic drain();
        while (in_flight > 0 || expected_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_digit_count(input logic [3:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        digit_count_model = (value < 1) ? 1 : (value > MAX_DIGITS) ? MAX_DIGITS : value;
    endtask

    task automatic queue_row(input plan_row_t row);
        in_flight++;
        cmd_fifo.push_back(row);
    endtask

    plan_row_t directed_rows[N_DIRECTED] = '{
        '{cmd: '{operation: OP_ENABLE, enable_on: 1'b0, default: '0},
          typed: 1'b1, has_word: 1'b1, exp_addr: REG_SHUT, exp_data: 8'h00, default: '0},
        '{cmd: '{operation: OP_ENABLE, enable_on: 1'b1, default: '0},
          typed: 1'b1, has_word: 1'b1, exp_addr: REG_SHUT, exp_data: 8'h01, default: '0},
        '{cmd: '{operation: OP_BRIGHT, brightness: 8'hFF, default: '0},
          typed: 1'b1, has_word: 1'b1, exp_addr: REG_INTENS, exp_data: 8'h0F, default: '0},
        '{cmd: '{operation: OP_BRIGHT, brightness: 8'h00, default: '0},
          typed: 1'b1, has_word: 1'b1, exp_addr: REG_INTENS, exp_data: 8'h00, default: '0},
        '{cmd: '{operation: OP_NUMBER, number: 32'sd0, default: '0},
          typed: 1'b1, has_word: 1'b1, exp_addr: REG_DIGIT0, exp_data: 8'h00, default: '0},
        '{cmd: '{operation: OP_NUMBER, number: 32'sh8000_0000, default: '0},
          typed: 1'b1, has_word: 1'b1, exp_addr: REG_DIGIT0, exp_data: 8'h07, default: '0},
        // digit out of range and state code on one digit: no word
        '{cmd: '{operation: OP_DIGIT, digit_index: 3'd7, digit_code: 8'h35, default: '0},
          typed: 1'b1, has_word: 1'b0, default: '0},
        '{cmd: '{operation: OP_STATE, left_char: "H", right_char: "O", default: '0},
          typed: 1'b1, has_word: 1'b0, default: '0},
        '{cmd: '{operation: OP_DIGIT, digit_index: 3'd0, digit_code: 8'hFF, point_on: 1'b1,
                 default: '0},
          typed: 1'b1, has_word: 1'b1, exp_addr: REG_DIGIT0, exp_data: 8'h8F, default: '0},
        '{cfg_row: 1'b1, cfg_value: 4'd8, default: '0},
        '{cmd: '{operation: OP_INIT, default: '0}, default: '0},
        '{cmd: '{operation: OP_NUMBER, number: 32'sh7FFF_FFFF, default: '0}, default: '0},
        '{cmd: '{operation: OP_NUMBER, number: 32'sh8000_0000, default: '0}, default: '0},
        '{cmd: '{operation: OP_NUMBER, number: -32'sd5, default: '0}, default: '0},
        '{cmd: '{operation: OP_STATE, left_char: "H", right_char: "O", default: '0},
          default: '0},
        '{cmd: '{operation: OP_STATE, left_char: "Z", right_char: " ", default: '0},
          default: '0},
        '{cmd: '{operation: OP_DIGIT, digit_index: 3'd7, digit_code: 8'h09, default: '0},
          default: '0},
        '{cmd: '{operation: OP_STATE, left_char: " ", right_char: "t", default: '0},
          default: '0},
        '{cmd: '{operation: OP_DASH, default: '0}, default: '0},
        '{cmd: '{operation: OP_CLEAR, default: '0}, default: '0},
        '{cfg_row: 1'b1, cfg_value: 4'd15, default: '0},
        '{cmd: '{operation: OP_NUMBER, number: -32'sd1234, default: '0}, default: '0},
        '{cfg_row: 1'b1, cfg_value: 4'd0, default: '0},
        '{cmd: '{operation: OP_NUMBER, number: -32'sd1, default: '0}, default: '0},
        '{cfg_row: 1'b1, cfg_value: 4'd2, default: '0},
        '{cmd: '{operation: OP_STATE, left_char: "a", right_char: "s", default: '0},
          default: '0},
        '{cmd: '{operation: OP_NUMBER, number: -32'sd9, default: '0}, default: '0}
    };

    initial
    begin
        string     left_letters;
        string     right_letters;
        plan_row_t row;
        int        pick;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        left_letters   = "HhIiAaFfDdSs ";
        right_letters  = "OoDdTtSsAaFf ";
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].cfg_row)
                set_digit_count(directed_rows[r].cfg_value);
            else
                queue_row(directed_rows[r]);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 40 == 39)
                set_digit_count(4'($urandom_range(0, 15)));
            if (n == N_RANDOM - 30)
            begin
                drain();
                steady_flow = 1'b1;
            end
            row = '0;
            row.cmd = command_t'(72'({$urandom, $urandom, $urandom}));
            pick = $urandom_range(0, 99);
            row.cmd.operation = (pick < 5)  ? OP_INIT   : (pick < 35) ? OP_NUMBER :
                                (pick < 50) ? OP_DIGIT  : (pick < 55) ? OP_CLEAR  :
                                (pick < 60) ? OP_DASH   : (pick < 80) ? OP_STATE  :
                                (pick < 90) ? OP_BRIGHT : OP_ENABLE;
            case ($urandom_range(0, 3))
                0: row.cmd.number = $urandom;
                1: row.cmd.number = int'($urandom_range(0, 1998)) - 999;
                2: row.cmd.number = int'($urandom_range(0, 199999998)) - 99999999;
                default:
                    case ($urandom_range(0, 3))
                        0: row.cmd.number = 32'sh8000_0000;
                        1: row.cmd.number = 32'sh7FFF_FFFF;
                        2: row.cmd.number = -32'sd1;
                        default: row.cmd.number = 32'sd0;
                    endcase
            endcase
            // mostly known letters so the segment tables get exercised
            if ($urandom_range(0, 2) != 0)
            begin
                row.cmd.left_char  = left_letters[$urandom_range(0, left_letters.len() - 1)];
                row.cmd.right_char = right_letters[$urandom_range(0, right_letters.len() - 1)];
            end
            if ($urandom_range(0, 1) == 0)
                row.cmd.brightness = 8'($urandom_range(0, 20));
            queue_row(row);
            while (cmd_fifo.size() > 2)
                @(posedge clk);
        end

        drain();
        if (errors == 0 && expected_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
